// ===== hdl/fds_pkg.sv =====
// ----------------------------------------------------------------------------
// fds_pkg: shared types and constants for the frontmatter delimiter scan
// Byte codes, scan phases, the scan state record and the word layouts that
// the input stage, the scan core and the top level all use.
// ----------------------------------------------------------------------------
package fds_pkg;

  // Width of the internal byte position counter. Offsets leave the block
  // on fixed 32-bit fields.
  localparam int unsigned PosBits = 32;
  localparam int unsigned OutBits = 32;

  typedef logic [PosBits-1:0] pos_t;
  typedef logic [OutBits-1:0] off_t;

  localparam pos_t PosMax = {PosBits{1'b1}};

  // Character codes.
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] Bom0    = 8'hEF;
  localparam logic [7:0] Bom1    = 8'hBB;
  localparam logic [7:0] Bom2    = 8'hBF;

  // Body offset reported when no frontmatter exists but a mark was skipped.
  localparam off_t MarkLen = off_t'(3);
  // Number of dashes or dots in a delimiter.
  localparam logic [1:0] MarkerCount = 2'd3;

  typedef enum logic [3:0] {
    PhMark0     = 4'd0,
    PhMark1     = 4'd1,
    PhMark2     = 4'd2,
    PhOpen      = 4'd3,
    PhOpenTail  = 4'd4,
    PhOpenCr    = 4'd5,
    PhLineStart = 4'd6,
    PhCand      = 4'd7,
    PhCandTail  = 4'd8,
    PhMid       = 4'd9,
    PhAfterCr   = 4'd10,
    PhIdle      = 4'd11
  } phase_e;

  typedef struct packed {
    pos_t       byte_position;
    phase_e     scan_phase;
    logic [1:0] marker_progress;
    logic       marker_is_dots;
    logic       mark_seen;
    pos_t       block_begin;
    pos_t       line_end_candidate;
    logic       previous_was_cr;
    pos_t       block_length;
    pos_t       body_begin;
    logic       closing_found;
    logic       saturated;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    byte_position:      '0,
    scan_phase:         PhMark0,
    marker_progress:    2'd0,
    marker_is_dots:     1'b0,
    mark_seen:          1'b0,
    block_begin:        '0,
    line_end_candidate: '0,
    previous_was_cr:    1'b0,
    block_length:       '0,
    body_begin:         '0,
    closing_found:      1'b0,
    saturated:          1'b0
  };

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic found;
    logic bom_present;
    off_t frontmatter_start;
    off_t frontmatter_length;
    off_t body_offset;
    off_t total_length;
    logic too_long;
  } out_word_t;

endpackage

// ===== hdl/fds_in_if.sv =====
// ----------------------------------------------------------------------------
// fds_in_if: input byte channel
// Valid/ready channel that carries one document byte word per transfer.
// ----------------------------------------------------------------------------
interface fds_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output has_byte, output data_byte, output last,
                  input ready);
  modport sink (input valid, input has_byte, input data_byte, input last,
                output ready);
endinterface

// ===== hdl/fds_out_if.sv =====
// ----------------------------------------------------------------------------
// fds_out_if: result channel
// Valid/ready channel that carries one document summary word per transfer.
// ----------------------------------------------------------------------------
interface fds_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        bom_present;
  logic [31:0] frontmatter_start;
  logic [31:0] frontmatter_length;
  logic [31:0] body_offset;
  logic [31:0] total_length;
  logic        too_long;

  modport source (output valid, output found, output bom_present,
                  output frontmatter_start, output frontmatter_length,
                  output body_offset, output total_length, output too_long,
                  input ready);
  modport sink (input valid, input found, input bom_present,
                input frontmatter_start, input frontmatter_length,
                input body_offset, input total_length, input too_long,
                output ready);
endinterface

// ===== hdl/fds_in_stage.sv =====
// ----------------------------------------------------------------------------
// fds_in_stage: input register
// Captures one input word; refills in the same cycle the core takes it.
// ----------------------------------------------------------------------------
module fds_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  fds_in_if.sink            in_i,
  input  logic              advance_i,
  output logic              word_valid_o,
  output fds_pkg::in_word_t word_o
);

  logic              valid_q, valid_d;
  fds_pkg::in_word_t word_q;
  logic              load;

  // The register is free when empty or when its word moves on this cycle.
  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= '{has_byte: in_i.has_byte, data_byte: in_i.data_byte, last: in_i.last};
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

// ===== hdl/fds_scan_core.sv =====
// ----------------------------------------------------------------------------
// fds_scan_core: delimiter scan state and result register
// Updates the scan state with one byte per cycle unless a held result stalls
// it, and registers the summary of a document when its last word passes.
// ----------------------------------------------------------------------------
module fds_scan_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              word_valid_i,
  input  fds_pkg::in_word_t word_i,
  output logic              advance_o,
  fds_out_if.source         out_o
);

  fds_pkg::scan_state_t st_q, st_d, st_n;
  fds_pkg::out_word_t   res_q, res_d;
  logic                 res_valid_q, res_valid_d;
  logic                 take;

  function automatic fds_pkg::pos_t sat_next(fds_pkg::pos_t p);
    return (p == fds_pkg::PosMax) ? fds_pkg::PosMax : p + fds_pkg::pos_t'(1);
  endfunction

  function automatic fds_pkg::scan_state_t note_line_feed(fds_pkg::scan_state_t s,
                                                          fds_pkg::pos_t p);
    fds_pkg::scan_state_t r;
    r = s;
    r.line_end_candidate = (s.previous_was_cr && (p != '0)) ? p - fds_pkg::pos_t'(1) : p;
    r.scan_phase = fds_pkg::PhLineStart;
    return r;
  endfunction

  // A dash or dot at column 0 opens a candidate closing line; the block length
  // up to the preceding line break is latched at that point.
  function automatic fds_pkg::scan_state_t col0_byte(fds_pkg::scan_state_t s,
                                                     logic [7:0] b,
                                                     fds_pkg::pos_t p);
    fds_pkg::scan_state_t r;
    r = s;
    if (b == fds_pkg::ChDash || b == fds_pkg::ChDot) begin
      r.scan_phase      = fds_pkg::PhCand;
      r.marker_progress = 2'd1;
      r.marker_is_dots  = (b == fds_pkg::ChDot);
      if (p == s.block_begin || s.line_end_candidate < s.block_begin) begin
        r.block_length = '0;
      end else begin
        r.block_length = s.line_end_candidate - s.block_begin;
      end
    end else if (b == fds_pkg::ChLf) begin
      r = note_line_feed(s, p);
    end else begin
      r.scan_phase = fds_pkg::PhMid;
    end
    return r;
  endfunction

  assign advance_o = !res_valid_q || out_o.ready;
  assign take      = word_valid_i && advance_o;

  // Next scan state after the byte of the current word.
  always_comb begin
    logic [7:0]    b;
    fds_pkg::pos_t p;
    logic          blank;
    logic          is_cr;
    logic [7:0]    want;
    b     = word_i.data_byte;
    p     = st_q.byte_position;
    blank = (b == fds_pkg::ChSpace) || (b == fds_pkg::ChTab);
    is_cr = (b == fds_pkg::ChCr);
    want  = st_q.marker_is_dots ? fds_pkg::ChDot : fds_pkg::ChDash;
    st_n  = st_q;
    if (word_i.has_byte) begin
      unique case (st_q.scan_phase)
        fds_pkg::PhMark0: begin
          if (b == fds_pkg::Bom0) begin
            st_n.scan_phase = fds_pkg::PhMark1;
          end else if (b == fds_pkg::ChDash) begin
            st_n.scan_phase      = fds_pkg::PhOpen;
            st_n.marker_progress = 2'd1;
          end else begin
            st_n.scan_phase = fds_pkg::PhIdle;
          end
        end
        fds_pkg::PhMark1: begin
          st_n.scan_phase = (b == fds_pkg::Bom1) ? fds_pkg::PhMark2 : fds_pkg::PhIdle;
        end
        fds_pkg::PhMark2: begin
          if (b == fds_pkg::Bom2) begin
            st_n.mark_seen       = 1'b1;
            st_n.scan_phase      = fds_pkg::PhOpen;
            st_n.marker_progress = 2'd0;
          end else begin
            st_n.scan_phase = fds_pkg::PhIdle;
          end
        end
        fds_pkg::PhOpen: begin
          if (b == fds_pkg::ChDash) begin
            st_n.marker_progress = st_q.marker_progress + 2'd1;
            if (st_n.marker_progress == fds_pkg::MarkerCount) begin
              st_n.scan_phase = fds_pkg::PhOpenTail;
            end
          end else begin
            st_n.scan_phase = fds_pkg::PhIdle;
          end
        end
        fds_pkg::PhOpenTail: begin
          if (b == fds_pkg::ChLf) begin
            st_n.block_begin     = sat_next(p);
            st_n.previous_was_cr = 1'b0;
            st_n.scan_phase      = fds_pkg::PhLineStart;
          end else if (is_cr) begin
            st_n.scan_phase = fds_pkg::PhOpenCr;
          end else if (!blank) begin
            st_n.scan_phase = fds_pkg::PhIdle;
          end
        end
        fds_pkg::PhOpenCr: begin
          if (b == fds_pkg::ChLf) begin
            st_n.block_begin     = sat_next(p);
            st_n.previous_was_cr = 1'b0;
            st_n.scan_phase      = fds_pkg::PhLineStart;
          end else begin
            // A lone CR ended the opening line: the block starts at this byte.
            st_n.block_begin     = p;
            st_n                 = col0_byte(st_n, b, p);
            st_n.previous_was_cr = is_cr;
          end
        end
        fds_pkg::PhLineStart: begin
          st_n                 = col0_byte(st_q, b, p);
          st_n.previous_was_cr = is_cr;
        end
        fds_pkg::PhCand: begin
          if (b == want) begin
            st_n.marker_progress = st_q.marker_progress + 2'd1;
            if (st_n.marker_progress == fds_pkg::MarkerCount) begin
              st_n.scan_phase = fds_pkg::PhCandTail;
            end
          end else if (b == fds_pkg::ChLf) begin
            st_n = note_line_feed(st_q, p);
          end else begin
            st_n.scan_phase = fds_pkg::PhMid;
          end
          st_n.previous_was_cr = is_cr;
        end
        fds_pkg::PhCandTail: begin
          if (b == fds_pkg::ChLf || is_cr) begin
            st_n.closing_found = 1'b1;
            st_n.body_begin    = sat_next(p);
            st_n.scan_phase    = is_cr ? fds_pkg::PhAfterCr : fds_pkg::PhIdle;
          end else if (!blank) begin
            st_n.scan_phase = fds_pkg::PhMid;
          end
          st_n.previous_was_cr = is_cr;
        end
        fds_pkg::PhMid: begin
          if (b == fds_pkg::ChLf) begin
            st_n = note_line_feed(st_q, p);
          end
          st_n.previous_was_cr = is_cr;
        end
        fds_pkg::PhAfterCr: begin
          if (b == fds_pkg::ChLf) begin
            st_n.body_begin = sat_next(p);
          end
          st_n.scan_phase = fds_pkg::PhIdle;
        end
        default: begin
          st_n.scan_phase = fds_pkg::PhIdle;
        end
      endcase
      if (p == fds_pkg::PosMax) begin
        st_n.saturated = 1'b1;
      end else begin
        st_n.byte_position = p + fds_pkg::pos_t'(1);
      end
    end
  end

  // Document summary from the state after the last byte.
  always_comb begin
    logic          closed;
    fds_pkg::pos_t body;
    closed = st_n.closing_found || (st_n.scan_phase == fds_pkg::PhCandTail);
    body   = (st_n.scan_phase == fds_pkg::PhCandTail) ? st_n.byte_position
                                                      : st_n.body_begin;
    res_d.found              = closed;
    res_d.bom_present        = st_n.mark_seen;
    res_d.frontmatter_start  = closed ? fds_pkg::off_t'(st_n.block_begin) : '0;
    res_d.frontmatter_length = closed ? fds_pkg::off_t'(st_n.block_length) : '0;
    res_d.body_offset        = closed ? fds_pkg::off_t'(body)
                             : (st_n.mark_seen ? fds_pkg::MarkLen : '0);
    res_d.total_length       = fds_pkg::off_t'(st_n.byte_position);
    res_d.too_long           = st_n.saturated;
  end

  always_comb begin
    st_d        = st_q;
    res_valid_d = res_valid_q;
    if (advance_o) begin
      res_valid_d = take && word_i.last;
    end
    if (take) begin
      st_d = word_i.last ? fds_pkg::ScanReset : st_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= fds_pkg::ScanReset;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && word_i.last) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = res_valid_q;
  assign out_o.found              = res_q.found;
  assign out_o.bom_present        = res_q.bom_present;
  assign out_o.frontmatter_start  = res_q.frontmatter_start;
  assign out_o.frontmatter_length = res_q.frontmatter_length;
  assign out_o.body_offset        = res_q.body_offset;
  assign out_o.total_length       = res_q.total_length;
  assign out_o.too_long           = res_q.too_long;

endmodule

// ===== hdl/frontmatter_delimiter_scan_unit.sv =====
// An accepted word is held in the input stage until the core applies it to
// the scan state; on a last word the result register takes the summary.
// Throughput: one word per cycle, limited only by the output side holding a
// result; the scan state next-state logic is combinational.
// Reset: asynchronous and active low; it empties both registers and returns
// the scan to the start of a document. No clearing pass is needed.
// ----------------------------------------------------------------------------
// frontmatter_delimiter_scan_unit: YAML frontmatter delimiter scanner
// Streams a document one byte word at a time, skips an optional UTF-8 byte
// order mark, matches the "---" opening line and the "---" or "..." closing
// line, and reports frontmatter and body offsets on the last word.
// ----------------------------------------------------------------------------
// The design is two registers deep. The input stage holds one word and
// refills whenever the core consumes it, so a continuously streaming source
// sees ready high unless a held result stalls. The core advances whenever its
// result register is empty or being read, applies the byte to the scan state,
// and on a last word loads the document summary and restarts the scan for the
// next document in the same cycle. Offsets count from the first document
// byte; a byte order mark is included in them. Once the position counter
// reaches its maximum, it holds there and too_long is reported.
module frontmatter_delimiter_scan_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  fds_in_if.sink    in_i,
  fds_out_if.source out_o
);

  logic              advance;
  logic              word_valid;
  fds_pkg::in_word_t word;

  fds_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .advance_i    (advance),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  fds_scan_core u_scan_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .word_i       (word),
    .advance_o    (advance),
    .out_o        (out_o)
  );

endmodule

// ===== hdl/fds_checker.sv =====
// ----------------------------------------------------------------------------
// fds_checker: port-level checks for the frontmatter delimiter scanner
// Watches the result channel and checks consistency of reported offsets.
// ----------------------------------------------------------------------------
module fds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        found_i,
  input logic        bom_present_i,
  input logic [31:0] frontmatter_start_i,
  input logic [31:0] frontmatter_length_i,
  input logic [31:0] body_offset_i,
  input logic [31:0] total_length_i,
  input logic        too_long_i
);

  // A result that is not taken stays valid, with found, body offset and total length unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(found_i)
      && $stable(body_offset_i) && $stable(total_length_i))
    else $error("result changed while stalled");

  // Without frontmatter, its offsets are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> frontmatter_start_i == 32'd0
      && frontmatter_length_i == 32'd0)
    else $error("frontmatter offsets set without a match");

  // Without frontmatter, the body starts right after the byte order mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> body_offset_i == (bom_present_i ? 32'd3 : 32'd0))
    else $error("body start wrong without a match");

  // With frontmatter, the block lies inside the document and before the body.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i && !too_long_i |-> frontmatter_start_i <= body_offset_i
      && body_offset_i <= total_length_i)
    else $error("frontmatter offsets out of order");

endmodule

bind frontmatter_delimiter_scan_unit fds_checker u_fds_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .found_i              (out_o.found),
  .bom_present_i        (out_o.bom_present),
  .frontmatter_start_i  (out_o.frontmatter_start),
  .frontmatter_length_i (out_o.frontmatter_length),
  .body_offset_i        (out_o.body_offset),
  .total_length_i       (out_o.total_length),
  .too_long_i           (out_o.too_long)
);
